### src/lprg_pkg.sv
// ----------------------------------------------------------------------------
// lprg_pkg
// Types, codes and constants for the long-press reset gesture block.
// ----------------------------------------------------------------------------
package lprg_pkg;

  localparam int unsigned TimeW     = 16;
  localparam int unsigned ElapsedW  = 10;
  localparam int unsigned IntervalW = 10;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 16;

  // Blink half-period is (PeriodMax - held * PeriodSpan / arm) / 2.
  localparam int unsigned PeriodMax  = 500;
  localparam int unsigned PeriodSpan = 400;
  localparam int unsigned QuoW       = 9;   // quotient stays below PeriodSpan
  localparam int unsigned ProdW      = TimeW + QuoW;
  localparam int unsigned HalfW      = 8;
  localparam int unsigned CntW       = 4;

  localparam logic [TimeW-1:0]     ArmTimeReset      = 16'd6000;
  localparam logic [IntervalW-1:0] RingIntervalReset = 10'd60;
  localparam logic [TimeW-1:0]     TimeSat           = '1;

  typedef enum logic [CfgAddrW-1:0] {
    REG_ARM_TIME      = 2'd0,
    REG_RING_INTERVAL = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RING_NONE = 2'd0,
    RING_RED  = 2'd1,
    RING_OFF  = 2'd2
  } ring_cmd_e;

  typedef enum logic [1:0] {
    STG_WAIT = 2'd0,
    STG_HOLD = 2'd1,
    STG_DONE = 2'd2
  } stage_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_EVAL  = 3'd1,
    S_ARM   = 3'd2,
    S_DIV   = 3'd3,
    S_BLINK = 3'd4,
    S_EMIT  = 3'd5
  } seq_state_e;

  // Saturating add of a millisecond step onto a 16-bit timer.
  function automatic logic [TimeW-1:0] sat_add16(input logic [TimeW-1:0] a,
                                                 input logic [ElapsedW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {{(TimeW + 1 - ElapsedW){1'b0}}, b};
    return s[TimeW] ? TimeSat : s[TimeW-1:0];
  endfunction

endpackage

### src/long_press_reset_gesture.sv
// ----------------------------------------------------------------------------
// long_press_reset_gesture
// Power-up long-press erase gesture with blink pacing and ring rate limiting.
// ----------------------------------------------------------------------------
// Usage: each input transfer is one poll sample (button_down_i, elapsed_ms_i)
// on a valid/stall channel. Every sample yields exactly one result transfer
// (led_on_o, ring_command_o, erase_commit_o, finished_o) on the output
// valid/stall channel, in order.
// Steps: a held sample that is not yet armed goes through evaluate, arm
// check, the 9-step restoring divider that derives the blink half-period
// (held * 400 / arm time), blink and emit. A held sample that arms or is
// already armed goes through evaluate, arm check and emit; a release or a
// sample after the end, through evaluate and emit. The input stays stalled
// while a sample is worked on, until its result enters the output register.
// The output register holds a result until it is taken; a new sample can be
// accepted meanwhile, and its result waits until the register frees up.
// Reset clears the gesture to "waiting for first sample", loads the
// register defaults (arm time 6000 ms, ring interval 60 ms) and empties the
// output register. Configuration writes land at once and should only be made
// while no sample is in flight.
// ----------------------------------------------------------------------------
module long_press_reset_gesture (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lprg_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [lprg_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              button_down_i,
  input  logic [lprg_pkg::ElapsedW-1:0]     elapsed_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              led_on_o,
  output logic [1:0]                        ring_command_o,
  output logic                              erase_commit_o,
  output logic                              finished_o
);
  import lprg_pkg::*;

  seq_state_e state_q, state_d;

  logic [TimeW-1:0]     arm_time_q;
  logic [IntervalW-1:0] ring_interval_q;

  stage_e               stage_q;
  logic [TimeW-1:0]     held_q;
  logic [TimeW-1:0]     phase_q;
  logic                 blink_lit_q;
  logic                 ring_lit_q;
  logic                 armed_q;
  logic [TimeW-1:0]     ring_since_q;

  logic                 down_q;
  logic [ElapsedW-1:0]  elapsed_q;
  logic [ElapsedW-1:0]  step_q;

  logic [TimeW-1:0]     rem_q;
  logic [QuoW-1:0]      lo_q;
  logic [QuoW-1:0]      quo_q;
  logic [CntW-1:0]      cnt_q;

  logic                 res_led_q;
  ring_cmd_e            res_ring_q;
  logic                 res_erase_q;
  logic                 res_fin_q;

  logic                 out_valid_q;
  logic                 out_led_q;
  ring_cmd_e            out_ring_q;
  logic                 out_erase_q;
  logic                 out_fin_q;

  logic                 in_xfer;
  logic                 out_free;
  logic                 div_last;
  logic [ElapsedW-1:0]  eval_step;
  logic [ProdW-1:0]     prod;
  logic [TimeW:0]       trial;
  logic                 trial_ge;
  logic [QuoW-1:0]      period;
  logic [HalfW-1:0]     half;
  logic [TimeW-1:0]     phase_new;
  logic                 blink_new;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign div_last = (cnt_q == CntW'(QuoW - 1));

  // The first held sample counts as a zero-length step.
  assign eval_step = (stage_q == STG_WAIT) ? '0 : elapsed_q;

  // Shared datapath: one multiply for the dividend, one subtract per step.
  assign prod      = ProdW'(held_q) * ProdW'(PeriodSpan);
  assign trial     = {rem_q, lo_q[QuoW-1]};
  assign trial_ge  = (trial >= {1'b0, arm_time_q});
  assign period    = QuoW'(PeriodMax) - quo_q;
  assign half      = period[QuoW-1:1];
  assign phase_new = sat_add16(phase_q, step_q);
  assign blink_new = (phase_new >= {{(TimeW - HalfW){1'b0}}, half}) ? !blink_lit_q
                                                                    : blink_lit_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (down_q && (stage_q == STG_WAIT || stage_q == STG_HOLD)) begin
          state_d = S_ARM;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_ARM: begin
        state_d = (held_q >= arm_time_q) ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        if (div_last) state_d = S_BLINK;
      end
      S_BLINK: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o     = (state_q != S_IDLE);
    out_valid_o    = out_valid_q;
    led_on_o       = out_led_q;
    ring_command_o = out_ring_q;
    erase_commit_o = out_erase_q;
    finished_o     = out_fin_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_time_q      <= ArmTimeReset;
      ring_interval_q <= RingIntervalReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ARM_TIME:      arm_time_q      <= cfg_wdata_i;
        REG_RING_INTERVAL: ring_interval_q <= cfg_wdata_i[IntervalW-1:0];
        default: ;
      endcase
    end
  end

  // Gesture state and per-sample result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q      <= STG_WAIT;
      held_q       <= '0;
      phase_q      <= '0;
      blink_lit_q  <= 1'b0;
      ring_lit_q   <= 1'b0;
      armed_q      <= 1'b0;
      ring_since_q <= TimeSat;
      res_led_q    <= 1'b0;
      res_ring_q   <= RING_NONE;
      res_erase_q  <= 1'b0;
      res_fin_q    <= 1'b0;
    end else begin
      case (state_q)
        S_EVAL: begin
          res_led_q   <= 1'b0;
          res_ring_q  <= RING_NONE;
          res_erase_q <= 1'b0;
          res_fin_q   <= 1'b0;
          case (stage_q)
            STG_WAIT, STG_HOLD: begin
              if (!down_q) begin
                stage_q   <= STG_DONE;
                res_fin_q <= 1'b1;
                if (stage_q == STG_HOLD) begin
                  res_ring_q  <= RING_OFF;
                  res_erase_q <= armed_q;
                end
              end else begin
                stage_q      <= STG_HOLD;
                ring_since_q <= sat_add16(ring_since_q, eval_step);
                held_q       <= sat_add16(held_q, eval_step);
              end
            end
            default: res_fin_q <= 1'b1;
          endcase
        end
        S_ARM: begin
          if (held_q >= arm_time_q) begin
            if (!armed_q) begin
              res_ring_q <= RING_RED;
              ring_lit_q <= 1'b1;
            end
            armed_q   <= 1'b1;
            res_led_q <= 1'b1;
          end
        end
        S_BLINK: begin
          phase_q     <= (blink_new != blink_lit_q) ? '0 : phase_new;
          blink_lit_q <= blink_new;
          res_led_q   <= blink_new;
          if (blink_new != ring_lit_q &&
              ring_since_q >= {{(TimeW - IntervalW){1'b0}}, ring_interval_q}) begin
            ring_lit_q   <= blink_new;
            ring_since_q <= '0;
            res_ring_q   <= blink_new ? RING_RED : RING_OFF;
          end
        end
        default: ;
      endcase
    end
  end

  // Sample latch and divider registers; payload only.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      down_q    <= button_down_i;
      elapsed_q <= elapsed_ms_i;
    end
    if (state_q == S_EVAL) begin
      step_q <= eval_step;
    end
    if (state_q == S_ARM) begin
      // Quotient fits in QuoW bits, so the upper dividend part is below arm.
      rem_q <= prod[ProdW-1:QuoW];
      lo_q  <= prod[QuoW-1:0];
      quo_q <= '0;
      cnt_q <= '0;
    end else if (state_q == S_DIV) begin
      rem_q <= trial_ge ? TimeW'(trial - {1'b0, arm_time_q}) : trial[TimeW-1:0];
      lo_q  <= {lo_q[QuoW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], trial_ge};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Output register: holds a result until the receiver takes the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      out_led_q   <= res_led_q;
      out_ring_q  <= res_ring_q;
      out_erase_q <= res_erase_q;
      out_fin_q   <= res_fin_q;
    end
  end

endmodule
